// ----- design/tcw_pkg.sv -----
// Shared constants, payload types and helpers for the text console writer.
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int NCELLS    = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CNT_W  = $clog2(NCELLS + 1);

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [7:0] BLANK_ATTR = 8'h07;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       char_code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_item_t;

  // Outcome of one put-character command
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             scroll;
    logic             wr_en;
    logic [15:0]      wr_data;
  } put_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ----- design/tcw_cursor.sv -----
// Cursor movement and cell write for one put-character command.
module tcw_cursor (
  input  logic [tcw_pkg::COL_W-1:0] cur_col,
  input  logic [tcw_pkg::ROW_W-1:0] cur_row,
  input  logic [7:0]                char_code,
  input  logic [7:0]                old_char,
  output tcw_pkg::put_t             put
);

  logic [tcw_pkg::COL_W:0] tab_col;
  logic [tcw_pkg::COL_W:0] inc_col;
  logic                    line_feed;
  logic                    last_row;

  assign tab_col  = {1'b0, cur_col} + (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_WIDTH)
                  - (tcw_pkg::COL_W+1)'(cur_col % tcw_pkg::TAB_WIDTH);
  assign inc_col  = {1'b0, cur_col} + 1'b1;
  assign last_row = (cur_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));

  always_comb begin
    put.col     = cur_col;
    put.row     = cur_row;
    put.scroll  = 1'b0;
    put.wr_en   = 1'b0;
    put.wr_data = {tcw_pkg::BLANK_ATTR, char_code};
    line_feed   = 1'b0;
    unique case (char_code)
      tcw_pkg::CH_NL: begin
        line_feed = 1'b1;
      end
      tcw_pkg::CH_BS: begin
        if (cur_col != '0) begin
          put.wr_en   = 1'b1;
          put.wr_data = {8'h00, old_char};
          put.col     = cur_col - 1'b1;
        end
      end
      tcw_pkg::CH_TAB: begin
        if (tab_col >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
          line_feed = 1'b1;
        end else begin
          put.col = tab_col[tcw_pkg::COL_W-1:0];
        end
      end
      tcw_pkg::CH_CR: begin
        put.col = '0;
      end
      default: begin
        put.wr_en = 1'b1;
        if (inc_col >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
          line_feed = 1'b1;
        end else begin
          put.col = inc_col[tcw_pkg::COL_W-1:0];
        end
      end
    endcase
    if (line_feed) begin
      put.col = '0;
      // past the bottom row: scroll and stay on the last row
      if (last_row) begin
        put.scroll = 1'b1;
      end else begin
        put.row = cur_row + 1'b1;
      end
    end
  end

endmodule

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: screen memory, sequencer and cursor.
//
//  channel | ports                       | direction | moves
//  --------+-----------------------------+-----------+------------------------
//  input   | in_valid, in_stall, in_data | in        | one command per transfer
//  output  | out_valid, out_stall,       | out       | cursor and read cell,
//          | out_data                    |           | one per command
//
// A command first reads the screen memory, then writes back and loads the
// result register. A scroll adds a copy sweep through the single-port-write
// memory; a clear adds a sweep of every cell.
// After reset the memory is swept to zero before the first transfer is
// taken. A stalled result holds the block in its execute state.
module text_console_writer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_CLEAR  = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tcw_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [tcw_pkg::COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    cur_row_r, cur_row_nxt;
  tcw_pkg::in_item_t            item_r;
  logic [tcw_pkg::ADDR_W-1:0]   addr_r;
  logic                         out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t           out_item_r, out_item_nxt;

  logic [15:0]                  mem [tcw_pkg::NCELLS];
  logic [15:0]                  rd_data_r;
  logic                         mem_re, mem_we;
  logic [tcw_pkg::ADDR_W-1:0]   mem_raddr, mem_waddr, acc_addr;
  logic [15:0]                  mem_wdata;

  logic                         accept;
  logic                         exec_go;
  logic                         rd_in_range;
  tcw_pkg::put_t                put;

  tcw_cursor u_cursor (
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .char_code (item_r.char_code),
    .old_char  (rd_data_r[7:0]),
    .put       (put)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign rd_in_range = (item_r.col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                       (item_r.row < tcw_pkg::ROW_W'(tcw_pkg::ROWS));

  assign acc_addr = (in_data.mode == tcw_pkg::MODE_READ)
                  ? tcw_pkg::cell_addr(in_data.row, in_data.col)
                  : tcw_pkg::cell_addr(cur_row_r, cur_col_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    mem_re        = 1'b0;
    mem_raddr     = acc_addr;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = put.wr_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mem_re    = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          cnt_nxt       = '0;
          out_item_nxt.cell_char = 8'h00;
          out_item_nxt.cell_attr = 8'h00;
          unique case (item_r.mode)
            tcw_pkg::MODE_PUT: begin
              mem_we      = put.wr_en;
              cur_col_nxt = put.col;
              cur_row_nxt = put.row;
              if (put.scroll) begin
                state_nxt = S_SCROLL;
              end
            end
            tcw_pkg::MODE_READ: begin
              if (rd_in_range) begin
                out_item_nxt.cell_char = rd_data_r[7:0];
                out_item_nxt.cell_attr = rd_data_r[15:8];
              end
            end
            tcw_pkg::MODE_SET: begin
              cur_col_nxt = (item_r.col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
                          ? item_r.col : tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
              cur_row_nxt = (item_r.row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                          ? item_r.row : tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
            end
            tcw_pkg::MODE_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
          out_item_nxt.cursor_col = cur_col_nxt;
          out_item_nxt.cursor_row = cur_row_nxt;
        end
      end
      S_SCROLL: begin
        // read runs one row ahead of the write; the bottom row is blanked
        mem_raddr = tcw_pkg::ADDR_W'(cnt_r + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
        mem_re    = (cnt_r < tcw_pkg::CNT_W'(tcw_pkg::NCELLS - tcw_pkg::COLUMNS));
        mem_waddr = tcw_pkg::ADDR_W'(cnt_r - 1'b1);
        mem_we    = (cnt_r != '0);
        mem_wdata = (cnt_r <= tcw_pkg::CNT_W'(tcw_pkg::NCELLS - tcw_pkg::COLUMNS))
                  ? rd_data_r : {tcw_pkg::BLANK_ATTR, 8'h00};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == tcw_pkg::CNT_W'(tcw_pkg::NCELLS)) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_waddr = tcw_pkg::ADDR_W'(cnt_r);
        mem_we    = 1'b1;
        mem_wdata = 16'h0000;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == tcw_pkg::CNT_W'(tcw_pkg::NCELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (accept) begin
      item_r <= in_data;
      addr_r <= acc_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule
